### sv/lbsc_pkg.sv
// Shared types and constants for the LRU block slot cache.
// Used by lbsc_ctrl, lbsc_datapath and lru_block_slot_cache_core.
package lbsc_pkg;

   localparam int unsigned SLOTS_DEFAULT = 4;
   localparam int unsigned INDEX_W       = 16;
   localparam int unsigned SLOT_W        = 4;
   localparam int unsigned STAMP_W       = 32;
   localparam int unsigned COUNT_W       = 17;

   typedef enum logic [1:0] {
      STATUS_HIT     = 2'd0,
      STATUS_MISS    = 2'd1,
      STATUS_RANGE   = 2'd2,
      STATUS_EMPTIED = 2'd3
   } status_type;

   typedef struct packed {
      logic capture;
      logic commit;
      logic scan_init;
      logic scan_step;
   } cmd_type;

   typedef struct packed {
      logic quick;
      logic scan_last;
      logic out_free;
   } sts_type;

endpackage

### sv/lbsc_ctrl.sv
// Controller state machine of the LRU block slot cache.
// Depends on lbsc_pkg; drives commands into lbsc_datapath.
module lbsc_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  lbsc_pkg::sts_type sts,
   output lbsc_pkg::cmd_type cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_EVAL,
      S_SCAN,
      S_DONE
   } state_type;

   state_type state_ff;
   logic      ready_ff;

   assign req_tready = ready_ff;

   always_comb begin
      cmd = '0;
      case (state_ff)
         S_IDLE: begin
            cmd.capture = req_tvalid;
         end
         S_EVAL: begin
            if (sts.quick) begin
               cmd.commit = sts.out_free;
            end else begin
               cmd.scan_init = 1'b1;
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
         end
         S_DONE: begin
            cmd.commit = sts.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ready_ff <= 1'b1;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  state_ff <= S_EVAL;
                  ready_ff <= 1'b0;
               end
            end
            S_EVAL: begin
               if (!sts.quick) begin
                  state_ff <= S_SCAN;
               end else if (sts.out_free) begin
                  state_ff <= S_IDLE;
                  ready_ff <= 1'b1;
               end
            end
            S_SCAN: begin
               if (sts.scan_last) begin
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (sts.out_free) begin
                  state_ff <= S_IDLE;
                  ready_ff <= 1'b1;
               end
            end
            default: begin
               state_ff <= S_IDLE;
               ready_ff <= 1'b1;
            end
         endcase
      end
   end

endmodule

### sv/lbsc_datapath.sv
// Datapath of the LRU block slot cache: slot tags, stamps, use clock,
// oldest-stamp scan and response register. Depends on lbsc_pkg.
module lbsc_datapath #(
   parameter int unsigned SLOTS = lbsc_pkg::SLOTS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [lbsc_pkg::COUNT_W-1:0]    csr_wr_data,
   input  logic                            req_mode,
   input  logic [lbsc_pkg::INDEX_W-1:0]    req_index,
   input  logic [lbsc_pkg::SLOT_W-1:0]     req_fslot,
   input  lbsc_pkg::cmd_type               cmd,
   output lbsc_pkg::sts_type               sts,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [1:0]                      rsp_status,
   output logic [lbsc_pkg::SLOT_W-1:0]     rsp_slot
);

   localparam int unsigned SW = $clog2(SLOTS);
   localparam int unsigned IW = lbsc_pkg::INDEX_W;
   localparam int unsigned TW = lbsc_pkg::STAMP_W;
   localparam int unsigned FW = lbsc_pkg::SLOT_W;

   logic                         mode_ff;
   logic [IW-1:0]                index_ff;
   logic [FW-1:0]                fslot_ff;
   logic [lbsc_pkg::COUNT_W-1:0] block_count_ff;
   logic [SLOTS-1:0]             valid_ff;
   logic [IW-1:0]                tag_ff [SLOTS];
   logic [TW-1:0]                stamp_ff [SLOTS];
   logic [TW-1:0]                clock_ff;
   logic [SW-1:0]                scan_idx_ff;
   logic [SW-1:0]                best_idx_ff;
   logic [TW-1:0]                best_stamp_ff;
   logic                         rsp_valid_ff;
   lbsc_pkg::status_type         rsp_status_ff;
   logic [FW-1:0]                rsp_slot_ff;

   logic                         hit;
   logic [SW-1:0]                hit_idx;
   logic                         has_empty;
   logic [SW-1:0]                empty_idx;
   logic                         fslot_ok;
   logic                         range_bad;
   logic [SW-1:0]                victim;
   logic [TW-1:0]                clock_next;
   logic [TW-1:0]                cand_stamp;
   logic                         cand_lt;
   lbsc_pkg::status_type         res_status;
   logic [FW-1:0]                res_slot;

   always_comb begin
      hit       = 1'b0;
      hit_idx   = '0;
      has_empty = 1'b0;
      empty_idx = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (valid_ff[i] && (tag_ff[i] == index_ff)) begin
            hit     = 1'b1;
            hit_idx = SW'(i);
         end
         if (!valid_ff[i]) begin
            has_empty = 1'b1;
            empty_idx = SW'(i);
         end
      end
   end

   assign fslot_ok   = (5'(fslot_ff) < 5'(SLOTS));
   assign range_bad  = ({1'b0, index_ff} >= block_count_ff);
   assign victim     = has_empty ? empty_idx : best_idx_ff;
   assign clock_next = clock_ff + 32'd1;
   assign cand_stamp = stamp_ff[scan_idx_ff];
   assign cand_lt    = (cand_stamp < best_stamp_ff);

   assign sts.quick     = mode_ff || range_bad || hit || has_empty;
   assign sts.scan_last = (scan_idx_ff == SW'(SLOTS - 1));
   assign sts.out_free  = !rsp_valid_ff || rsp_tready;

   always_comb begin
      if (mode_ff) begin
         res_status = fslot_ok ? lbsc_pkg::STATUS_EMPTIED : lbsc_pkg::STATUS_RANGE;
         res_slot   = fslot_ff;
      end else if (range_bad) begin
         res_status = lbsc_pkg::STATUS_RANGE;
         res_slot   = '0;
      end else if (hit) begin
         res_status = lbsc_pkg::STATUS_HIT;
         res_slot   = FW'(hit_idx);
      end else begin
         res_status = lbsc_pkg::STATUS_MISS;
         res_slot   = FW'(victim);
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         block_count_ff <= '0;
         valid_ff       <= '0;
         clock_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            block_count_ff <= csr_wr_data;
         end
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
            if (mode_ff) begin
               if (fslot_ok) begin
                  valid_ff[fslot_ff[SW-1:0]] <= 1'b0;
               end
            end else if (!range_bad) begin
               clock_ff <= clock_next;
               if (!hit) begin
                  valid_ff[victim] <= 1'b1;
               end
            end
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff  <= req_mode;
         index_ff <= req_index;
         fslot_ff <= req_fslot;
      end
      if (cmd.scan_init) begin
         best_idx_ff   <= '0;
         best_stamp_ff <= stamp_ff[0];
         scan_idx_ff   <= SW'(1);
      end else if (cmd.scan_step) begin
         if (cand_lt) begin
            best_idx_ff   <= scan_idx_ff;
            best_stamp_ff <= cand_stamp;
         end
         scan_idx_ff <= scan_idx_ff + SW'(1);
      end
      if (cmd.commit) begin
         rsp_status_ff <= res_status;
         rsp_slot_ff   <= res_slot;
         if (!mode_ff && !range_bad) begin
            if (hit) begin
               stamp_ff[hit_idx] <= clock_next;
            end else begin
               tag_ff[victim]   <= index_ff;
               stamp_ff[victim] <= clock_next;
            end
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_slot   = rsp_slot_ff;

endmodule

### sv/lru_block_slot_cache_core.sv
// LRU block slot cache, top level.
// Usage:
//   A request on req_* is either a lookup of a block index (req_tuser = 0)
//   or a report that filling a slot failed (req_tuser = 1). Each request
//   yields one response on rsp_*: status in rsp_tuser, slot in rsp_tdata.
//   csr_wr_en/csr_wr_data set the block count; write it only while idle.
// Timing:
//   Hits, out-of-range lookups, fill-failed reports and misses with an
//   empty slot are committed from state EVAL once the response register
//   is free. A miss with every slot in use first scans the stamps one
//   slot per cycle in state SCAN, then commits from state DONE.
//   One request is in flight at a time; req_tready is high only when idle.
// Reset:
//   Synchronous; all slots empty, use clock and block count zero.
// Stalls:
//   The response register holds while rsp_tready is low; the next request
//   may be accepted meanwhile but its commit waits for the register.
// Depends on lbsc_pkg, lbsc_ctrl and lbsc_datapath.
module lru_block_slot_cache_core #(
   parameter int unsigned SLOTS = lbsc_pkg::SLOTS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [16:0] csr_wr_data,   // block_count
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,     // [15:0] block_index, [19:16] failed_slot
   input  logic        req_tuser,     // [0] mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,     // [3:0] slot
   output logic [1:0]  rsp_tuser      // [1:0] status
);

   lbsc_pkg::cmd_type cmd;
   lbsc_pkg::sts_type sts;
   logic [lbsc_pkg::SLOT_W-1:0] rsp_slot;

   lbsc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   lbsc_datapath #(
      .SLOTS (SLOTS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_mode    (req_tuser),
      .req_index   (req_tdata[15:0]),
      .req_fslot   (req_tdata[19:16]),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_status  (rsp_tuser),
      .rsp_slot    (rsp_slot)
   );

   assign rsp_tdata = {4'd0, rsp_slot};

`ifndef SYNTHESIS
   a_commit_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> sts.out_free)
      else $error("commit while response register is occupied");

   a_capture_alone: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |-> !(cmd.commit || cmd.scan_init || cmd.scan_step))
      else $error("capture overlaps another command");

   a_busy_after_capture: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> !req_tready)
      else $error("ready high right after a request was taken");

   a_commit_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_tvalid)
      else $error("commit did not produce a response");
`endif

endmodule
